[src/cdta_pkg.sv]
// Package for the calendar date-time adder: field widths, word packing and the
// calendar helpers. It depends on nothing else.
package cdta_pkg;

    localparam int unsigned IN_DATA_W = 88;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned WALK_STAGES = 12;

    typedef struct packed {
        logic [7:0] add_secs;
        logic [7:0] add_minutes;
        logic [7:0] add_hours;
        logic [7:0] add_days;
        logic [7:0] add_months;
        logic [7:0] add_years;
        logic [5:0] start_sec;
        logic [5:0] start_minute;
        logic [4:0] start_hour;
        logic [4:0] start_day;
        logic [3:0] start_month;
        logic [7:0] start_year;
    } t_in_word;

    typedef struct packed {
        logic [5:0] result_sec;
        logic [5:0] result_minute;
        logic [4:0] result_hour;
        logic [4:0] result_day;
        logic [3:0] result_month;
        logic [7:0] result_year;
    } t_out_word;

    // Working state carried down the walk pipeline.
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [8:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] sec;
        logic [7:0] add_years;
        logic [7:0] add_months;
    } t_work;

    // Within 2000..2255 the century rule only excludes 2100 and 2200.
    function automatic logic leap_year(input logic [7:0] year_off);
        leap_year = (year_off[1:0] == 2'd0) && (year_off != 8'd100) &&
                    (year_off != 8'd200);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [7:0] year_off);
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: month_length = 5'd30;
            4'd2: month_length = leap_year(year_off) ? 5'd29 : 5'd28;
            default: month_length = 5'd31;
        endcase
    endfunction

endpackage

[src/cdta_walk_stage.sv]
// One month step of the day walk, registered, with its own valid bit.
// Depends on cdta_pkg.
module cdta_walk_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cdta_pkg::t_work i_work,
    output logic            o_valid,
    output cdta_pkg::t_work o_work
);
    import cdta_pkg::*;

    logic [4:0] len;
    t_work      n_work;
    t_work      r_work;
    logic       r_valid;

    always_comb begin
        len = month_length(i_work.month, i_work.year);
        n_work = i_work;
        if (i_work.day > {4'd0, len}) begin
            n_work.day = i_work.day - {4'd0, len};
            if (i_work.month == 4'd12) begin
                n_work.month = 4'd1;
                n_work.year = i_work.year + 8'd1;
            end else begin
                n_work.month = i_work.month + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work = r_work;
endmodule

[src/calendar_date_time_adder.sv]
// Top level of the calendar date-time adder: time carry, month walk and
// month/year carry stages. Depends on cdta_pkg and cdta_walk_stage.
//
// Channel  Dir  Contents
// s_axis   in   start date-time and amounts to add
// m_axis   out  resulting date-time
//
// A word passes through 15 register stages: two for the time carries, twelve
// month steps, and the output register, which also takes the month and year carry.
// A new word may enter every cycle. Reset is synchronous and empties the pipe.
// When the output is stalled the whole pipe holds; nothing is lost.
module calendar_date_time_adder #(
    parameter int unsigned WALK_DEPTH = cdta_pkg::WALK_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start_year, start_month, start_day, start_hour, start_minute,
    // start_sec, add_years, add_months, add_days, add_hours, add_minutes,
    // add_secs
    input  logic [cdta_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // result_year, result_month, result_day, result_hour, result_minute,
    // result_sec
    output logic [cdta_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import cdta_pkg::*;

    logic       en;
    t_in_word   in_w;
    assign in_w = t_in_word'(s_axis_tdata[81:0]);
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: normalise, seconds and minutes carry.
    logic       r_v1;
    logic [7:0] r1_year;
    logic [3:0] r1_month;
    logic [4:0] r1_day;
    logic [8:0] r1_hour;
    logic [5:0] r1_minute;
    logic [5:0] r1_sec;
    logic [7:0] r1_add_years, r1_add_months, r1_add_days;
    logic [3:0] n1_month;
    logic [7:0] n1_year;
    logic [8:0] s_sum;
    logic [8:0] m_sum;
    logic [1:0] s_q;
    logic [2:0] m_q;
    logic [8:0] s_rem, m_rem;

    always_comb begin
        n1_month = in_w.start_month;
        n1_year = in_w.start_year;
        if (n1_month == 4'd0) begin
            n1_month = 4'd1;
        end
        if (n1_month > 4'd12) begin
            n1_month = n1_month - 4'd12;
            n1_year = n1_year + 8'd1;
        end
        s_sum = {3'd0, in_w.start_sec} + {1'd0, in_w.add_secs};
        s_q = (s_sum >= 9'd240) ? 2'd0 : (s_sum >= 9'd180) ? 2'd3 :
              (s_sum >= 9'd120) ? 2'd2 : (s_sum >= 9'd60) ? 2'd1 : 2'd0;
        if (s_sum >= 9'd240) begin
            s_q = 2'd0;
        end
        s_rem = s_sum - 9'd60 * {7'd0, s_q};
        // s_sum < 319, so quotient up to 5 may arise; handled through m_sum.
        m_sum = {3'd0, in_w.start_minute} + {1'd0, in_w.add_minutes};
        if (s_sum >= 9'd300) begin
            m_sum = m_sum + 9'd5;
            s_rem = s_sum - 9'd300;
        end else if (s_sum >= 9'd240) begin
            m_sum = m_sum + 9'd4;
            s_rem = s_sum - 9'd240;
        end else begin
            m_sum = m_sum + {7'd0, s_q};
        end
        m_q = (m_sum >= 9'd300) ? 3'd5 : (m_sum >= 9'd240) ? 3'd4 :
              (m_sum >= 9'd180) ? 3'd3 : (m_sum >= 9'd120) ? 3'd2 :
              (m_sum >= 9'd60) ? 3'd1 : 3'd0;
        m_rem = m_sum - 9'd60 * {6'd0, m_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
        if (en) begin
            r1_year <= n1_year;
            r1_month <= n1_month;
            r1_day <= (in_w.start_day == 5'd0) ? 5'd1 : in_w.start_day;
            r1_hour <= {4'd0, in_w.start_hour} + {1'd0, in_w.add_hours} + {6'd0, m_q};
            r1_minute <= m_rem[5:0];
            r1_sec <= s_rem[5:0];
            r1_add_years <= in_w.add_years;
            r1_add_months <= in_w.add_months;
            r1_add_days <= in_w.add_days;
        end
    end

    // Stage 2: hours carry into days.
    logic       r_v2;
    t_work      r2_work;
    logic [3:0] h_q;
    logic [8:0] h_rem;

    always_comb begin
        h_q = 4'd0;
        for (int k = 1; k < 13; k++) begin
            if (r1_hour >= 9'(24 * k)) begin
                h_q = 4'(k);
            end
        end
        h_rem = r1_hour - 9'd24 * {5'd0, h_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r2_work.year <= r1_year;
            r2_work.month <= r1_month;
            r2_work.day <= {4'd0, r1_day} + {1'd0, r1_add_days} + {5'd0, h_q};
            r2_work.hour <= h_rem[4:0];
            r2_work.minute <= r1_minute;
            r2_work.sec <= r1_sec;
            r2_work.add_years <= r1_add_years;
            r2_work.add_months <= r1_add_months;
        end
    end

    // Month walk.
    logic  v_chain [WALK_DEPTH+1];
    t_work w_chain [WALK_DEPTH+1];
    assign v_chain[0] = r_v2;
    assign w_chain[0] = r2_work;

    for (genvar g = 0; g < WALK_DEPTH; g++) begin : g_walk
        cdta_walk_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[g]),
            .i_work  (w_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_work  (w_chain[g+1])
        );
    end

    // Final stage: months carry into years.
    t_work      wf;
    logic [8:0] mo_sum;
    logic [4:0] mo_q;
    logic [8:0] mo_rem;
    t_out_word  n_out;
    t_out_word  r_out;
    logic       r_out_valid;

    always_comb begin
        wf = w_chain[WALK_DEPTH];
        mo_sum = {5'd0, wf.month} - 9'd1 + {1'd0, wf.add_months};
        mo_q = 5'd0;
        for (int k = 1; k < 23; k++) begin
            if (mo_sum >= 9'(12 * k)) begin
                mo_q = 5'(k);
            end
        end
        mo_rem = mo_sum - 9'd12 * {4'd0, mo_q};
        n_out.result_year = wf.year + {3'd0, mo_q} + wf.add_years;
        n_out.result_month = mo_rem[3:0] + 4'd1;
        n_out.result_day = wf.day[4:0];
        n_out.result_hour = wf.hour;
        n_out.result_minute = wf.minute;
        n_out.result_sec = wf.sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_chain[WALK_DEPTH];
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {6'd0, r_out};

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");
    a_month : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:8] >= 4'd1 && m_axis_tdata[11:8] <= 4'd12)
        else $error("month out of range");
    a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:17] < 5'd24 && m_axis_tdata[27:22] < 6'd60 &&
        m_axis_tdata[33:28] < 6'd60)
        else $error("time field out of range");
    a_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output");
endmodule

[test/calendar_date_time_adder_test.sv]
// Testbench for calendar_date_time_adder: drives date-time additions on the input
// stream and checks every output word against a behavioural calendar predictor.
// Depends on cdta_pkg and the adder RTL.
`timescale 1ns / 1ps

module calendar_date_time_adder_test;
    import cdta_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_in_word pending_sums[$];
    t_out_word expected_dates[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit stimulus_done = 0;

    calendar_date_time_adder i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_leap(input int unsigned yoff);
        int unsigned y;
        y = 2000 + (yoff & 255);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned yoff);
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        if (m == 2) return is_leap(yoff) ? 29 : 28;
        return 31;
    endfunction

    function automatic t_out_word add_date_time(input t_in_word w);
        int unsigned yr, mon, dy, hr, mn, sc, len;
        t_out_word r;
        yr = w.start_year; mon = w.start_month; dy = w.start_day;
        hr = w.start_hour; mn = w.start_minute; sc = w.start_sec;
        if (mon == 0) mon = 1;
        if (mon > 12) begin
            mon -= 12;
            yr = (yr + 1) & 255;
        end
        if (dy == 0) dy = 1;
        sc += w.add_secs;
        mn += w.add_minutes + sc / 60;
        sc %= 60;
        hr += w.add_hours + mn / 60;
        mn %= 60;
        dy += w.add_days + hr / 24;
        hr %= 24;
        len = days_in_month(mon, yr);
        while (dy > len) begin
            dy -= len;
            mon++;
            if (mon > 12) begin
                mon = 1;
                yr = (yr + 1) & 255;
            end
            len = days_in_month(mon, yr);
        end
        mon += w.add_months;
        yr += (mon - 1) / 12;
        mon = (mon - 1) % 12 + 1;
        yr = (yr + w.add_years) & 255;
        r.result_year = yr[7:0];
        r.result_month = mon[3:0];
        r.result_day = dy[4:0];
        r.result_hour = hr[4:0];
        r.result_minute = mn[5:0];
        r.result_sec = sc[5:0];
        return r;
    endfunction

    function automatic t_in_word random_sum(input bit wild);
        t_in_word w;
        w = '0;
        w.start_year = 8'($urandom);
        w.add_years = 8'($urandom);
        w.add_months = 8'($urandom);
        w.add_days = 8'($urandom);
        w.add_hours = 8'($urandom);
        w.add_minutes = 8'($urandom);
        w.add_secs = 8'($urandom);
        if (wild) begin
            w.start_month = 4'($urandom);
            w.start_day = 5'($urandom);
            w.start_hour = 5'($urandom);
            w.start_minute = 6'($urandom);
            w.start_sec = 6'($urandom);
        end else begin
            w.start_month = 4'($urandom_range(12, 1));
            w.start_day = 5'($urandom_range(days_in_month(w.start_month, w.start_year), 1));
            w.start_hour = 5'($urandom_range(23, 0));
            w.start_minute = 6'($urandom_range(59, 0));
            w.start_sec = 6'($urandom_range(59, 0));
            if ($urandom_range(3, 0) == 0) begin
                w.add_days = 8'($urandom_range(40, 0));
                w.add_hours = 8'($urandom_range(30, 0));
            end
        end
        return w;
    endfunction

    function automatic t_in_word make_sum(input int yr, mo, dy, hr, mn, sc,
                                          input int ay, am, ad, ah, ami, as_);
        t_in_word w;
        w.start_year = 8'(yr); w.start_month = 4'(mo); w.start_day = 5'(dy);
        w.start_hour = 5'(hr); w.start_minute = 6'(mn); w.start_sec = 6'(sc);
        w.add_years = 8'(ay); w.add_months = 8'(am); w.add_days = 8'(ad);
        w.add_hours = 8'(ah); w.add_minutes = 8'(ami); w.add_secs = 8'(as_);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                expected_dates.push_back(add_date_time(t_in_word'(s_axis_tdata[81:0])));
            end
            if (pending_sums.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_axis_tdata <= {6'd0, pending_sums.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= !i_rst_n ? 1'b0 : ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_word got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_out_word'(m_axis_tdata[33:0]);
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected word, year", got.result_year, -1);
            end else begin
                want = expected_dates.pop_front();
                if (got.result_year !== want.result_year)
                    report_mismatch("year", got.result_year, want.result_year);
                if (got.result_month !== want.result_month)
                    report_mismatch("month", got.result_month, want.result_month);
                if (got.result_day !== want.result_day)
                    report_mismatch("day", got.result_day, want.result_day);
                if (got.result_hour !== want.result_hour)
                    report_mismatch("hour", got.result_hour, want.result_hour);
                if (got.result_minute !== want.result_minute)
                    report_mismatch("minute", got.result_minute, want.result_minute);
                if (got.result_sec !== want.result_sec)
                    report_mismatch("second", got.result_sec, want.result_sec);
            end
        end
    end

    initial begin
        int wait_cycles;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_sums.push_back(make_sum(0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(255, 12, 31, 23, 59, 59, 255, 255, 255, 255, 255, 255));
        pending_sums.push_back(make_sum(255, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        pending_sums.push_back(make_sum(0, 2, 28, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        pending_sums.push_back(make_sum(100, 2, 28, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        pending_sums.push_back(make_sum(200, 2, 28, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        pending_sums.push_back(make_sum(4, 2, 29, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(10, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(10, 15, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(255, 13, 31, 31, 63, 63, 0, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(7, 4, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(7, 2, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(3, 1, 31, 12, 30, 30, 0, 1, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(3, 11, 15, 0, 0, 0, 0, 14, 0, 0, 0, 0));
        pending_sums.push_back(make_sum(50, 6, 1, 0, 0, 0, 0, 0, 255, 255, 0, 0));
        pending_sums.push_back(make_sum(0, 1, 1, 31, 63, 63, 255, 255, 255, 255, 255, 255));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 65; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 65; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < 488; n++)
                pending_sums.push_back(random_sum($urandom_range(9, 0) == 0));
            while (pending_sums.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        end
        stimulus_done = 1;

        wait_cycles = 0;
        while (expected_dates.size() > 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dates.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
src/cdta_pkg.sv
src/cdta_walk_stage.sv
src/calendar_date_time_adder.sv
test/calendar_date_time_adder_test.sv
